// ===== hw/rtl/hhg_pkg.sv =====
// Package for the hex hash glob matcher.
// Holds pattern sizes, symbol codes, register indexes and the decoded pattern type.
// No dependencies.
package hhg_pkg;

  localparam int PATTERN_MAX = 48;               // pattern symbols held
  localparam int POS_W       = PATTERN_MAX + 1;  // reachable positions 0..PATTERN_MAX
  localparam int SYM_W       = 5;
  localparam int NIBBLE_W    = 4;
  localparam int LEN_W       = 6;
  localparam int CFG_W       = 60;
  localparam int CFG_IDX_W   = 3;
  localparam int WORD_SYMS   = CFG_W / SYM_W;    // 12 symbols per pattern word
  localparam int NUM_WORDS   = 4;
  localparam int HASH_W      = 8;
  localparam int TDATA_W     = 8;

  localparam logic [SYM_W-1:0] SYM_STAR = 5'd16;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  // pattern in the form the matcher consumes
  typedef struct packed {
    logic [PATTERN_MAX-1:0][SYM_W-1:0] sym;   // symbol per position
    logic [PATTERN_MAX-1:0]            star;  // star at a position below the length
    logic [PATTERN_MAX-1:0]            live;  // position below the length
    logic [POS_W-1:0]                  keep;  // positions 0..length
    logic [LEN_W-1:0]                  len;   // saturated length
  } pat_ctl_t;

endpackage

// ===== hw/rtl/hex_hash_glob_matcher_top.sv =====
// Top level of the hex hash glob matcher.
// Depends on hhg_pkg, hhg_cfg_regs and hhg_nibble_step.

// Hash bytes enter on the s_ stream, one word per byte, s_tlast on the final
// byte. Each byte is two hex digits, high nibble first, matched against a glob
// pattern of up to 48 symbols (hex digit, '*' for any run of digits, or a
// never-matching code). A word enters the input register on acceptance and is
// processed from there; both nibble updates of the 49-bit reachable set are
// combinational, so one byte is taken every cycle, back to back, unless the
// input side stalls. Only the last byte of a hash yields a result word on m_
// (m_tdata[0] = matched), via the input and output registers; the set then
// restarts at position zero. The input side stalls only while a finished
// result waits in the output register and the next last byte needs that slot.
// Config writes (cfg_index 0..3 pattern words, 4 length, others ignored) are
// always ready and take effect for the next byte processed; write them only
// while no hash byte is in flight. There is no clearing pass after reset.
module hex_hash_glob_matcher_top (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hhg_pkg::TDATA_W-1:0]   s_tdata,   // [7:0] hash_byte
  input  logic                          s_tlast,   // last_byte
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hhg_pkg::TDATA_W-1:0]   m_tdata,   // [0] matched, [7:1] zero
  // config writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hhg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hhg_pkg::CFG_W-1:0]     cfg_data
);
  import hhg_pkg::*;

  pat_ctl_t pat;

  // input register
  logic              in_valid;
  logic [HASH_W-1:0] in_byte;
  logic              in_last;

  // reachable set, stored closed except the start value; closure is applied again on use
  logic [POS_W-1:0] reach;
  logic [POS_W-1:0] reach_mid;
  logic [POS_W-1:0] reach_end;

  // output register
  logic out_valid;
  logic out_matched;

  logic advance;

  hhg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  // high nibble first
  hhg_nibble_step u_step_hi (
    .pat       (pat),
    .reach_in  (reach),
    .nibble    (in_byte[HASH_W-1 -: NIBBLE_W]),
    .reach_out (reach_mid)
  );

  hhg_nibble_step u_step_lo (
    .pat       (pat),
    .reach_in  (reach_mid),
    .nibble    (in_byte[NIBBLE_W-1:0]),
    .reach_out (reach_end)
  );

  // a non-last byte never needs the output slot
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata[HASH_W-1:0];
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= POS_W'(1);
    end else if (advance) begin
      reach <= in_last ? POS_W'(1) : reach_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_matched <= reach_end[pat.len];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_W-1){1'b0}}, out_matched};

endmodule

// ===== hw/rtl/hhg_cfg_regs.sv =====
// Pattern configuration registers and pattern decode for the glob matcher.
// Depends on hhg_pkg.
module hhg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hhg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hhg_pkg::CFG_W-1:0]     cfg_data,
  output hhg_pkg::pat_ctl_t             pat
);
  import hhg_pkg::*;

  logic [NUM_WORDS-1:0][CFG_W-1:0] pattern_word;
  logic [LEN_W-1:0]                pattern_length;
  logic [LEN_W-1:0]                len_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LEN_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign len_sat = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pattern_length;

  always_comb begin
    pat.len = len_sat;
    for (int i = 0; i < POS_W; i++) begin
      pat.keep[i] = (LEN_W'(i) <= len_sat);
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pat.sym[k]  = pattern_word[k / WORD_SYMS][SYM_W*(k % WORD_SYMS) +: SYM_W];
      pat.live[k] = (LEN_W'(k) < len_sat);
      pat.star[k] = pat.live[k] && (pat.sym[k] == SYM_STAR);
    end
  end

endmodule

// ===== hw/rtl/hhg_nibble_step.sv =====
// One hex digit step of the glob matcher: star closure, advance, star closure.
// Depends on hhg_pkg.
module hhg_nibble_step (
  input  hhg_pkg::pat_ctl_t             pat,
  input  logic [hhg_pkg::POS_W-1:0]     reach_in,
  input  logic [hhg_pkg::NIBBLE_W-1:0]  nibble,
  output logic [hhg_pkg::POS_W-1:0]     reach_out
);
  import hhg_pkg::*;

  // prefix-OR along runs of stars, log depth (distances 1,2,4,...)
  function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] v,
                                                   input pat_ctl_t p_ctl);
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] p;
    g = v & p_ctl.keep;
    p = {p_ctl.star, 1'b0};  // position i is fed by a star at i-1
    for (int d = 1; d < POS_W; d = d * 2) begin
      g = g | (p & (g << d));
      p = p & (p << d);
    end
    return g;
  endfunction

  logic [POS_W-1:0]       closed;
  logic [PATTERN_MAX-1:0] hit;
  logic [POS_W-1:0]       advanced;

  always_comb begin
    closed = close_stars(reach_in, pat);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      hit[k] = pat.live[k] && (pat.sym[k] == SYM_W'(nibble));
    end
    advanced  = {1'b0, closed[PATTERN_MAX-1:0] & pat.star}
              | {closed[PATTERN_MAX-1:0] & hit, 1'b0};
    reach_out = close_stars(advanced, pat);
  end

endmodule

// ===== hw/rtl/hhg_checker.sv =====
// Port-level checks for the hex hash glob matcher, bound to the top level.
// Depends on hhg_pkg and hex_hash_glob_matcher_top.
module hhg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [hhg_pkg::TDATA_W-1:0]   s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hhg_pkg::TDATA_W-1:0]   m_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [hhg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [hhg_pkg::CFG_W-1:0]     cfg_data
);
  import hhg_pkg::*;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a fresh result comes from an accepted last byte
  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result word without a last byte");

  // input only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while result side free");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TDATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind hex_hash_glob_matcher_top hhg_checker u_hhg_checker (.*);
